[rtl/lapl_pkg.sv]
`default_nettype none

package lapl_pkg;

   // Lattice geometry. The side is a power of two, so coordinate wrap is
   // plain modular arithmetic on COORD_W bits.
   localparam int SIDE     = 16;
   localparam int COORD_W  = $clog2(SIDE);
   localparam int ADDR_W   = 3 * COORD_W;
   localparam int DATA_W   = 32;

   // Stencil sum: |sum| stays below 192 * 2^31, so 41 signed bits hold it.
   localparam int SUM_W    = 41;
   localparam int NUM_TAPS = 13;
   localparam int TAP_W    = $clog2(NUM_TAPS);

   // Scaling multiply: the sum is cut into a 20-bit unsigned low part and a
   // signed high part; each meets the 33-bit signed scale in its own cycle.
   localparam int SPLIT    = 20;
   localparam int MUL_A_W  = SUM_W - SPLIT;
   localparam int MUL_B_W  = DATA_W + 1;
   localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
   localparam int PROD_W   = SUM_W + MUL_B_W + 1;
   localparam int FRAC_W   = 16;

   localparam logic [DATA_W-1:0] SCALE_RESET = 32'h0001_0000;
   localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [TAP_W-1:0]   tap_type;

   typedef enum logic [1:0] {
      AC_IDLE,
      AC_READ,
      AC_DRAIN,
      AC_HAND
   } acc_state_type;

   typedef enum logic [2:0] {
      SC_IDLE,
      SC_LO,
      SC_HI,
      SC_ADD,
      SC_OUT
   } scl_state_type;

   typedef enum logic [1:0] {
      TAP_CENTER,
      TAP_NEAR,
      TAP_FAR
   } tap_kind_type;

   typedef struct packed {
      logic                en;
      logic                we;
      addr_type            addr;
      logic [DATA_W-1:0]   wdata;
   } ram_req_type;

   typedef struct packed {
      logic                    valid;
      logic signed [SUM_W-1:0] value;
   } sum_xfer_type;

   // Tap zero is the center point; the other twelve go axis by axis, each
   // axis in the order +2, +1, -1, -2.
   function automatic tap_kind_type tap_kind(tap_type tap);
      tap_type sel;
      tap_kind_type kind;
      sel = tap - tap_type'(1);
      if (tap == tap_type'(0)) begin
         kind = TAP_CENTER;
      end else if (sel[1] == sel[0]) begin
         kind = TAP_FAR;
      end else begin
         kind = TAP_NEAR;
      end
      return kind;
   endfunction

   function automatic addr_type tap_addr(coord_type x, coord_type y, coord_type z,
                                         tap_type tap);
      tap_type sel;
      coord_type ofs;
      coord_type ax;
      coord_type ay;
      coord_type az;
      sel = tap - tap_type'(1);
      ax  = x;
      ay  = y;
      az  = z;
      case (sel[1:0])
         2'd0:    ofs = coord_type'(2);
         2'd1:    ofs = coord_type'(1);
         2'd2:    ofs = coord_type'(SIDE - 1);
         default: ofs = coord_type'(SIDE - 2);
      endcase
      if (tap != tap_type'(0)) begin
         case (sel[3:2])
            2'd0:    ax = x + ofs;
            2'd1:    ay = y + ofs;
            default: az = z + ofs;
         endcase
      end
      return {ax, ay, az};
   endfunction

   function automatic logic signed [SUM_W-1:0] tap_term(logic [DATA_W-1:0] d, tap_type tap);
      logic signed [SUM_W-1:0] de;
      logic signed [SUM_W-1:0] term;
      de = {{(SUM_W-DATA_W){d[DATA_W-1]}}, d};
      case (tap_kind(tap))
         TAP_CENTER: term = -((de <<< 6) + (de <<< 4) + (de <<< 3) + (de <<< 1));
         TAP_NEAR:   term = de <<< 4;
         TAP_FAR:    term = -de;
         default:    term = '0;
      endcase
      return term;
   endfunction

endpackage

`default_nettype wire

[rtl/lapl_ram.sv]
`default_nettype none

module lapl_ram #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [DATA_W-1:0] wdata,
   output logic      [DATA_W-1:0] rdata
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end

endmodule

`default_nettype wire

[rtl/lapl_accum.sv]
`default_nettype none

module lapl_accum import lapl_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_type,
   input  wire coord_type         req_pos_x,
   input  wire coord_type         req_pos_y,
   input  wire coord_type         req_pos_z,
   input  wire logic [DATA_W-1:0] req_sample_value,
   output ram_req_type            ram_req,
   input  wire logic [DATA_W-1:0] ram_rdata,
   input  wire logic              scl_ready,
   output sum_xfer_type           sum_out
);

   acc_state_type state_ff, state_in;
   tap_type tap_ff, tap_in;
   tap_type rd_tap_ff;
   logic rd_valid_ff;
   coord_type x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic start;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= AC_IDLE;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= (state_ff == AC_READ);
      end
   end

   always_ff @(posedge clock) begin
      tap_ff    <= tap_in;
      rd_tap_ff <= tap_ff;
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      acc_ff    <= acc_in;
   end

   always_comb begin
      state_in      = state_ff;
      tap_in        = tap_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      start         = 1'b0;
      req_ready     = 1'b0;
      ram_req.en    = 1'b0;
      ram_req.we    = 1'b0;
      ram_req.addr  = {req_pos_x, req_pos_y, req_pos_z};
      ram_req.wdata = req_sample_value;
      sum_out.valid = 1'b0;
      sum_out.value = acc_ff;
      case (state_ff)
         AC_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_type == REQ_QUERY) begin
                  start    = 1'b1;
                  x_in     = req_pos_x;
                  y_in     = req_pos_y;
                  z_in     = req_pos_z;
                  tap_in   = '0;
                  state_in = AC_READ;
               end else begin
                  ram_req.en = 1'b1;
                  ram_req.we = 1'b1;
               end
            end
         end
         AC_READ: begin
            ram_req.en   = 1'b1;
            ram_req.addr = tap_addr(x_ff, y_ff, z_ff, tap_ff);
            if (tap_ff == tap_type'(NUM_TAPS - 1)) begin
               state_in = AC_DRAIN;
            end else begin
               tap_in = tap_ff + tap_type'(1);
            end
         end
         AC_DRAIN: begin
            state_in = AC_HAND;
         end
         AC_HAND: begin
            sum_out.valid = 1'b1;
            if (scl_ready) begin
               state_in = AC_IDLE;
            end
         end
         default: begin
            state_in = AC_IDLE;
         end
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if (start) begin
         acc_in = '0;
      end else if (rd_valid_ff) begin
         acc_in = acc_ff + tap_term(ram_rdata, rd_tap_ff);
      end
   end

`ifndef SYNTHESIS
   a_read_data_follows_read: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(state_ff == AC_READ))
      else $error("read data arrived without a read in flight");

   a_query_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_type == REQ_QUERY)
      |=> (state_ff == AC_READ && tap_ff == tap_type'(0)))
      else $error("accepted query did not start the tap sweep at the center");

   a_sum_complete_at_handoff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == AC_HAND) |-> !rd_valid_ff)
      else $error("sum handed off while a tap was still being accumulated");
`endif

endmodule

`default_nettype wire

[rtl/lapl_scale.sv]
`default_nettype none

module lapl_scale import lapl_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sum_xfer_type      sum_in,
   output logic                   scl_ready,
   input  wire logic [DATA_W-1:0] scale,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic signed [DATA_W-1:0] rsp_laplacian_value,
   output logic                   rsp_saturated
);

   localparam int SHIFT_W = PROD_W - FRAC_W;

   scl_state_type state_ff, state_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in_d;
   logic signed [MUL_P_W-1:0] p0_ff, p0_in, p1_ff, p1_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic sat_ff, sat_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;
   logic [SHIFT_W-1:0] shifted;
   logic [SHIFT_W-DATA_W:0] top_bits;
   logic fits;
   logic load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SC_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in_d;
      p0_ff    <= p0_in;
      p1_ff    <= p1_in;
      prod_ff  <= prod_in;
      value_ff <= value_in;
      sat_ff   <= sat_in;
   end

   // One shared multiplier, low half of the sum first, then the high half.
   always_comb begin
      if (state_ff == SC_LO) begin
         mul_a = {1'b0, sum_ff[SPLIT-1:0]};
      end else begin
         mul_a = sum_ff[SUM_W-1:SPLIT];
      end
      mul_b = {1'b0, scale};
      mul_p = mul_a * mul_b;
   end

   // Dropping the low fraction bits of a two's complement value is a floor.
   always_comb begin
      shifted  = prod_ff[PROD_W-1:FRAC_W];
      top_bits = shifted[SHIFT_W-1:DATA_W-1];
      fits     = (&top_bits) | ~(|top_bits);
   end

   always_comb begin
      state_in  = state_ff;
      sum_in_d  = sum_ff;
      p0_in     = p0_ff;
      p1_in     = p1_ff;
      prod_in   = prod_ff;
      value_in  = value_ff;
      sat_in    = sat_ff;
      scl_ready = 1'b0;
      load      = 1'b0;
      case (state_ff)
         SC_IDLE: begin
            scl_ready = 1'b1;
            if (sum_in.valid) begin
               sum_in_d = sum_in.value;
               state_in = SC_LO;
            end
         end
         SC_LO: begin
            p0_in    = mul_p;
            state_in = SC_HI;
         end
         SC_HI: begin
            p1_in    = mul_p;
            state_in = SC_ADD;
         end
         SC_ADD: begin
            prod_in  = ({{(PROD_W-MUL_P_W){p1_ff[MUL_P_W-1]}}, p1_ff} << SPLIT)
                     + {{(PROD_W-MUL_P_W){p0_ff[MUL_P_W-1]}}, p0_ff};
            state_in = SC_OUT;
         end
         SC_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load     = 1'b1;
               state_in = SC_IDLE;
               sat_in   = ~fits;
               if (fits) begin
                  value_in = shifted[DATA_W-1:0];
               end else if (shifted[SHIFT_W-1]) begin
                  value_in = VALUE_MIN;
               end else begin
                  value_in = VALUE_MAX;
               end
            end
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
      rsp_valid_in = load | (rsp_valid_ff & ~rsp_ready);
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_laplacian_value = value_ff;
   assign rsp_saturated       = sat_ff;

`ifndef SYNTHESIS
   a_load_shows_word: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("finished result was not presented on the response channel");

   a_saturated_value_is_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && sat_ff) |-> (value_ff == VALUE_MAX || value_ff == VALUE_MIN))
      else $error("saturation flag set on a value that is not a range limit");

   a_sum_taken: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SC_IDLE && sum_in.valid) |=> (state_ff == SC_LO))
      else $error("offered sum was not taken by the idle scaler");
`endif

endmodule

`default_nettype wire

[rtl/fourth_order_laplacian_stencil.sv]
`default_nettype none

// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  req_type, req_pos_x/y/z, req_sample_value
// rsp      out        rsp_valid / rsp_ready  rsp_laplacian_value, rsp_saturated
// csr      in         csr_valid / csr_ready  csr_data (stencil scale, unsigned Q16.16)
//
// A write word leaves the input ready; the sample lands in the lattice memory at the accept edge.
// A query word keeps the input busy through accept, 13 single-port reads, drain and hand-off.
// Scaling then steps through the low multiply, high multiply, add and output states, overlapped
// with the next word, and the result is registered for the response channel.
// Reset is synchronous and active high; it clears control state and sets the scale to 1.0 only.
// A stalled response holds in its output register; the next sum waits in the scaler and the
// query after that waits at the hand-off.

module fourth_order_laplacian_stencil import lapl_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_type,
   input  wire logic [3:0]        req_pos_x,
   input  wire logic [3:0]        req_pos_y,
   input  wire logic [3:0]        req_pos_z,
   input  wire logic signed [31:0] req_sample_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic signed [31:0]     rsp_laplacian_value,
   output logic                   rsp_saturated,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [31:0]       csr_data
);

   // The stencil scale register. Writes are always taken; the user changes it
   // only while no query is in flight.
   logic [DATA_W-1:0] scale_ff;

   ram_req_type ram_req;
   logic [DATA_W-1:0] ram_rdata;
   sum_xfer_type sum_xfer;
   logic scl_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_valid) begin
         scale_ff <= csr_data;
      end
   end

   // The lattice itself: one entry per point, addressed as {x, y, z}.
   lapl_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (DATA_W)
   ) u_ram (
      .clock (clock),
      .en    (ram_req.en),
      .we    (ram_req.we),
      .addr  (ram_req.addr),
      .wdata (ram_req.wdata),
      .rdata (ram_rdata)
   );

   // Sequencer: stores samples, or walks the thirteen taps of a query and
   // accumulates the weighted sum as the read data comes back.
   lapl_accum u_accum (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_sample_value (req_sample_value),
      .ram_req          (ram_req),
      .ram_rdata        (ram_rdata),
      .scl_ready        (scl_ready),
      .sum_out          (sum_xfer)
   );

   // Scaler: multiplies the sum by the scale in two halves, floors the product
   // back to Q16.16, saturates, and owns the response register.
   lapl_scale u_scale (
      .clock               (clock),
      .reset               (reset),
      .sum_in              (sum_xfer),
      .scl_ready           (scl_ready),
      .scale               (scale_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_laplacian_value (rsp_laplacian_value),
      .rsp_saturated       (rsp_saturated)
   );

endmodule

`default_nettype wire
